[hw/rtl/bhsp_pkg.sv]
// Package: parse phase codes, byte labels and magic bytes for the BAM header skip parser.
package bhsp_pkg;

   localparam int unsigned DataWidth  = 8;
   localparam int unsigned KindWidth  = 3;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned IndexWidth = 2;
   localparam int unsigned LenWidth   = 32;
   localparam int unsigned RefsWidth  = 31;

   typedef logic [DataWidth-1:0]  byte_type;
   typedef logic [KindWidth-1:0]  kind_type;
   typedef logic [PhaseWidth-1:0] phase_type;
   typedef logic [IndexWidth-1:0] index_type;
   typedef logic [LenWidth-1:0]   len_type;
   typedef logic [RefsWidth-1:0]  refs_type;

   localparam phase_type PH_MAGIC = 3'd0;
   localparam phase_type PH_TLEN  = 3'd1;
   localparam phase_type PH_TEXT  = 3'd2;
   localparam phase_type PH_NREF  = 3'd3;
   localparam phase_type PH_NLEN  = 3'd4;
   localparam phase_type PH_SKIP  = 3'd5;
   localparam phase_type PH_BODY  = 3'd6;
   localparam phase_type PH_ERR   = 3'd7;

   localparam kind_type KIND_MAGIC = 3'd0;
   localparam kind_type KIND_TLEN  = 3'd1;
   localparam kind_type KIND_TEXT  = 3'd2;
   localparam kind_type KIND_NREF  = 3'd3;
   localparam kind_type KIND_NLEN  = 3'd4;
   localparam kind_type KIND_SKIP  = 3'd5;
   localparam kind_type KIND_BODY  = 3'd6;
   localparam kind_type KIND_ERR   = 3'd7;

   localparam index_type LAST_FIELD_BYTE = 2'd3;
   localparam len_type   REF_LEN_BYTES   = 32'd4;

   function automatic byte_type magic_byte(input index_type idx);
      byte_type b;
      unique case (idx)
         2'd0: b = 8'h42;
         2'd1: b = 8'h41;
         2'd2: b = 8'h4d;
         2'd3: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[hw/rtl/bhsp_req_if.sv]
// Interface: input byte channel with valid/ready handshake.
interface bhsp_req_if;
   logic               valid;
   logic               ready;
   bhsp_pkg::byte_type data_byte;
   logic               stream_start;

   modport source (output valid, output data_byte, output stream_start, input ready);
   modport sink   (input valid, input data_byte, input stream_start, output ready);
   modport mon    (input valid, input data_byte, input stream_start, input ready);
endinterface

[hw/rtl/bhsp_rsp_if.sv]
// Interface: labeled byte result channel with valid/ready handshake.
interface bhsp_rsp_if;
   logic               valid;
   logic               ready;
   bhsp_pkg::byte_type byte_out;
   bhsp_pkg::kind_type byte_kind;
   logic               header_done;
   logic               parse_error;

   modport source (output valid, output byte_out, output byte_kind, output header_done,
                   output parse_error, input ready);
   modport sink   (input valid, input byte_out, input byte_kind, input header_done,
                   input parse_error, output ready);
   modport mon    (input valid, input byte_out, input byte_kind, input header_done,
                   input parse_error, input ready);
endinterface

[hw/rtl/bam_header_skip_parser.sv]
// Top level: BAM header skip parser that labels every byte of the stream.
//
// Takes a stream word and returns it in the next cycle with a label
// (magic, text length, text, reference count, name length, name or reference
// length, body, error), a header-done flag and a sticky parse-error flag.
// Throughput is one word per clock unless the output register holds a result
// that the sink has not taken; the result comes from the output register, and a
// new word is taken while the previous result waits as long as the sink takes
// it in the same cycle. A word with stream_start high restarts the parse as
// the first magic byte. A bad magic byte or a negative length or count puts
// the parser in the error phase until the next stream start.
module bam_header_skip_parser (
   input  logic        clock,
   input  logic        reset,
   bhsp_req_if.sink    req_ch,
   bhsp_rsp_if.source  rsp_ch
);
   import bhsp_pkg::*;

   phase_type phase_ff, phase_in;
   index_type idx_ff, idx_in;
   len_type   acc_ff, acc_in;
   len_type   skip_ff, skip_in;
   refs_type  refs_ff, refs_in;
   logic      err_ff, err_in;

   logic      out_valid_ff;
   byte_type  byte_out_ff;
   kind_type  kind_ff, kind_in;
   logic      done_ff;
   logic      perr_ff;

   logic      req_fire;
   byte_type  b;
   len_type   acc_new;
   len_type   skip_dec;
   refs_type  refs_dec;
   logic      field_last;
   logic      acc_zero;

   assign req_ch.ready = !out_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data_byte;

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      skip_in  = skip_ff;
      refs_in  = refs_ff;
      err_in   = err_ff;
      if (req_ch.stream_start) begin
         phase_in = PH_MAGIC;
         idx_in   = '0;
         acc_in   = '0;
         skip_in  = '0;
         refs_in  = '0;
         err_in   = 1'b0;
      end
      kind_in    = kind_type'(phase_in);
      acc_new    = acc_in | (len_type'(b) << {idx_in, 3'b000});
      field_last = (idx_in == LAST_FIELD_BYTE);
      acc_zero   = (acc_new == '0);
      skip_dec   = skip_in - len_type'(1);
      refs_dec   = refs_in - refs_type'(1);
      unique case (phase_in)
         PH_MAGIC: begin
            if (b != magic_byte(idx_in)) begin
               phase_in = PH_ERR;
               err_in   = 1'b1;
            end else if (field_last) begin
               phase_in = PH_TLEN;
               idx_in   = '0;
               acc_in   = '0;
            end else begin
               idx_in = idx_in + index_type'(1);
            end
         end
         PH_TLEN: begin
            acc_in = acc_new;
            idx_in = idx_in + index_type'(1);
            if (field_last) begin
               priority if (acc_new[LenWidth-1]) begin
                  phase_in = PH_ERR;
                  err_in   = 1'b1;
               end else if (acc_zero) begin
                  phase_in = PH_NREF;
                  idx_in   = '0;
                  acc_in   = '0;
               end else begin
                  skip_in  = acc_new;
                  phase_in = PH_TEXT;
               end
            end
         end
         PH_TEXT: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_NREF;
               idx_in   = '0;
               acc_in   = '0;
            end
         end
         PH_NREF: begin
            acc_in = acc_new;
            idx_in = idx_in + index_type'(1);
            if (field_last) begin
               priority if (acc_new[LenWidth-1]) begin
                  phase_in = PH_ERR;
                  err_in   = 1'b1;
               end else if (acc_zero) begin
                  phase_in = PH_BODY;
               end else begin
                  refs_in  = acc_new[RefsWidth-1:0];
                  phase_in = PH_NLEN;
                  idx_in   = '0;
                  acc_in   = '0;
               end
            end
         end
         PH_NLEN: begin
            acc_in = acc_new;
            idx_in = idx_in + index_type'(1);
            if (field_last) begin
               if (acc_new[LenWidth-1]) begin
                  phase_in = PH_ERR;
                  err_in   = 1'b1;
               end else begin
                  skip_in  = acc_new + REF_LEN_BYTES;
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               refs_in = refs_dec;
               if (refs_dec == '0) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_NLEN;
                  idx_in   = '0;
                  acc_in   = '0;
               end
            end
         end
         PH_BODY: begin
         end
         default: begin
            phase_in = PH_ERR;
            err_in   = 1'b1;
         end
      endcase
      if (phase_in == PH_ERR) begin
         kind_in = KIND_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         idx_ff       <= '0;
         acc_ff       <= '0;
         skip_ff      <= '0;
         refs_ff      <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            idx_ff       <= idx_in;
            acc_ff       <= acc_in;
            skip_ff      <= skip_in;
            refs_ff      <= refs_in;
            err_ff       <= err_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_out_ff <= b;
         kind_ff     <= kind_in;
         done_ff     <= (phase_in == PH_BODY);
         perr_ff     <= err_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.byte_out    = byte_out_ff;
   assign rsp_ch.byte_kind   = kind_ff;
   assign rsp_ch.header_done = done_ff;
   assign rsp_ch.parse_error = perr_ff;

endmodule

[hw/rtl/bhsp_checker.sv]
// Checker: port-level assertions for the BAM header skip parser, bound to the top level.
module bhsp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  bhsp_pkg::byte_type rsp_byte_out,
   input  bhsp_pkg::kind_type rsp_byte_kind,
   input  logic               rsp_header_done,
   input  logic               rsp_parse_error
);
   import bhsp_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out)
         && $stable(rsp_byte_kind))
      else $error("stalled result word changed");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word produced no result");

   a_error_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_kind == KIND_ERR |-> rsp_parse_error
         && !rsp_header_done)
      else $error("error label without sticky error");

   a_done_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_done |-> rsp_byte_kind == KIND_BODY
         || rsp_byte_kind == KIND_NREF || rsp_byte_kind == KIND_SKIP)
      else $error("header done on an unexpected label");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind bam_header_skip_parser bhsp_checker u_bhsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_byte_out    (rsp_ch.byte_out),
   .rsp_byte_kind   (rsp_ch.byte_kind),
   .rsp_header_done (rsp_ch.header_done),
   .rsp_parse_error (rsp_ch.parse_error)
);

[dv/tb.sv]
// Testbench for the BAM header skip parser: directed and random header streams checked against a label predictor.
module tb;
   import bhsp_pkg::*;

   typedef struct packed {
      byte_type data;
      kind_type kind;
      logic     done;
      logic     err;
   } labeled_word_type;

   typedef struct packed {
      byte_type b;
      logic     s;
   } stream_word_type;

   typedef enum int {
      FAULT_NONE,
      FAULT_MAGIC,
      FAULT_NEG_TLEN,
      FAULT_NEG_NREF,
      FAULT_NEG_NLEN,
      FAULT_HUGE
   } fault_type;

   localparam int HOLD_CYCLES  = 300;
   localparam int WATCHDOG_MAX = 2000;
   localparam int MAX_REPORTS  = 10;

   localparam byte_type MAGIC_SEQ [4] = '{8'h42, 8'h41, 8'h4d, 8'h01};

   logic clock = 1'b0;
   logic reset = 1'b1;

   bhsp_req_if req_if ();
   bhsp_rsp_if rsp_if ();

   bam_header_skip_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // label predictor state
   phase_type cur_phase;
   index_type field_idx;
   len_type   len_acc;
   len_type   skip_left;
   refs_type  refs_left;
   logic      err_sticky;

   labeled_word_type expected_labels[$];
   stream_word_type  stream_q[$];

   int  error_count   = 0;
   int  checked_count = 0;
   int  sent_count    = 0;
   int  idle_cycles   = 0;
   bit  idle_en       = 1'b1;
   bit  hold_req      = 1'b0;

   function automatic void clear_parse();
      cur_phase  = PH_MAGIC;
      field_idx  = '0;
      len_acc    = '0;
      skip_left  = '0;
      refs_left  = '0;
      err_sticky = 1'b0;
   endfunction

   function automatic void begin_field(input phase_type next_phase);
      cur_phase = next_phase;
      field_idx = '0;
      len_acc   = '0;
   endfunction

   function automatic void enter_error();
      cur_phase  = PH_ERR;
      err_sticky = 1'b1;
   endfunction

   function automatic logic collect_byte(input byte_type b);
      logic complete;
      len_acc   = len_acc | (len_type'(b) << (8 * field_idx));
      complete  = (field_idx == LAST_FIELD_BYTE);
      field_idx = field_idx + 1'b1;
      return complete;
   endfunction

   function automatic labeled_word_type label_byte(input byte_type b, input logic restart);
      labeled_word_type r;
      kind_type         k;
      if (restart) clear_parse();
      k = kind_type'(cur_phase);
      case (cur_phase)
         PH_MAGIC: begin
            if (b != MAGIC_SEQ[field_idx]) enter_error();
            else if (field_idx == LAST_FIELD_BYTE) begin_field(PH_TLEN);
            else field_idx = field_idx + 1'b1;
         end
         PH_TLEN: begin
            if (collect_byte(b)) begin
               if (len_acc[31]) enter_error();
               else if (len_acc == '0) begin_field(PH_NREF);
               else begin
                  skip_left = len_acc;
                  cur_phase = PH_TEXT;
               end
            end
         end
         PH_TEXT: begin
            skip_left = skip_left - 1;
            if (skip_left == '0) begin_field(PH_NREF);
         end
         PH_NREF: begin
            if (collect_byte(b)) begin
               if (len_acc[31]) enter_error();
               else if (len_acc == '0) cur_phase = PH_BODY;
               else begin
                  refs_left = len_acc[RefsWidth-1:0];
                  begin_field(PH_NLEN);
               end
            end
         end
         PH_NLEN: begin
            if (collect_byte(b)) begin
               if (len_acc[31]) enter_error();
               else begin
                  skip_left = len_acc + REF_LEN_BYTES;
                  cur_phase = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            skip_left = skip_left - 1;
            if (skip_left == '0) begin
               refs_left = refs_left - 1'b1;
               if (refs_left == '0) cur_phase = PH_BODY;
               else begin_field(PH_NLEN);
            end
         end
         PH_BODY: begin
         end
         default: enter_error();
      endcase
      if (cur_phase == PH_ERR) k = KIND_ERR;
      r.data = b;
      r.kind = k;
      r.done = (cur_phase == PH_BODY);
      r.err  = err_sticky;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_en) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic len_type huge_len();
      case ($urandom_range(0, 3))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         default: return len_type'($urandom);
      endcase
   endfunction

   function automatic len_type neg_len();
      return {1'b1, 31'($urandom)};
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                input logic [31:0] got_v);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch on word %0d, %s: expected %0h, got %0h",
                  checked_count, what, exp_v, got_v);
   endtask

   task automatic send_word(input byte_type b, input logic restart);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.data_byte    <= b;
      req_if.stream_start <= restart;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_labels.push_back(label_byte(b, restart));
      sent_count++;
   endtask

   task automatic send_field(input len_type v, input logic restart);
      for (int i = 0; i < 4; i++) send_word(v[8*i +: 8], restart && (i == 0));
   endtask

   task automatic push_field(input len_type v);
      for (int i = 0; i < 4; i++) stream_q.push_back('{b: v[8*i +: 8], s: 1'b0});
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++) stream_q.push_back('{b: byte_type'($urandom), s: 1'b0});
   endtask

   task automatic build_stream(input fault_type fault, input bit truncate);
      len_type  tlen, nref, nlen;
      byte_type b;
      int       bad_pos, n_refs, cut;
      stream_q.delete();
      bad_pos = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++) begin
         b = MAGIC_SEQ[i];
         if (fault == FAULT_MAGIC && i == bad_pos) b = b ^ (8'h01 << $urandom_range(0, 7));
         stream_q.push_back('{b: b, s: 1'b1 && (i == 0)});
      end
      tlen = ($urandom_range(0, 5) == 0) ? '0 : len_type'($urandom_range(1, 12));
      if (fault == FAULT_NEG_TLEN) tlen = neg_len();
      if (fault == FAULT_HUGE && $urandom_range(0, 1)) tlen = huge_len();
      push_field(tlen);
      if (!tlen[31]) push_random((tlen > 16) ? 16 : int'(tlen));
      nref = len_type'($urandom_range((fault == FAULT_NEG_NLEN) ? 1 : 0, 3));
      if (fault == FAULT_NEG_NREF) nref = neg_len();
      if (fault == FAULT_HUGE && $urandom_range(0, 1)) nref = huge_len();
      push_field(nref);
      n_refs = nref[31] ? 0 : ((nref > 3) ? 3 : int'(nref));
      for (int r = 0; r < n_refs; r++) begin
         nlen = ($urandom_range(0, 4) == 0) ? '0 : len_type'($urandom_range(1, 6));
         if (fault == FAULT_NEG_NLEN && r == 0) nlen = neg_len();
         if (fault == FAULT_HUGE && $urandom_range(0, 3) == 0) nlen = huge_len();
         push_field(nlen);
         if (!nlen[31]) push_random((nlen > 8) ? 8 : int'(nlen));
         push_random(4);
      end
      push_random($urandom_range(0, 8));
      if (truncate) begin
         cut = $urandom_range(1, stream_q.size());
         while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_word(stream_q[i].b, stream_q[i].s);
   endtask

   task automatic test_directed_header();
      // first stream right after reset, no restart flag
      foreach (MAGIC_SEQ[i]) send_word(MAGIC_SEQ[i], 1'b0);
      send_field(32'h0000_0000, 1'b0);
      send_field(32'h0000_0000, 1'b0);
      send_word(8'hff, 1'b0);
      send_word(8'h00, 1'b0);
      // bad first magic byte, then a byte after the error
      send_word(8'h5a, 1'b1);
      send_word(8'h42, 1'b0);
      // negative text length
      foreach (MAGIC_SEQ[i]) send_word(MAGIC_SEQ[i], i == 0);
      send_field(32'hffff_ffff, 1'b0);
   endtask

   task automatic test_wellformed_streams(input int target);
      while (sent_count < target) begin
         idle_en = ($urandom_range(0, 4) != 0);
         build_stream(FAULT_NONE, 1'b0);
         send_stream();
      end
      idle_en = 1'b1;
   endtask

   task automatic test_input_stall();
      idle_en  = 1'b0;
      hold_req = 1'b1;
      for (int i = 0; i < 3; i++) begin
         build_stream(FAULT_NONE, 1'b0);
         send_stream();
      end
      idle_en = 1'b1;
   endtask

   task automatic test_broken_streams(input int target);
      int r;
      while (sent_count < target) begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            build_stream(fault_type'($urandom_range(FAULT_MAGIC, FAULT_HUGE)),
                         $urandom_range(0, 1) == 1);
            send_stream();
         end else if (r < 7) begin
            repeat ($urandom_range(1, 12))
               send_word(byte_type'($urandom), $urandom_range(0, 7) == 0);
         end else begin
            build_stream(FAULT_NONE, $urandom_range(0, 2) == 0);
            send_stream();
         end
      end
   endtask

   // result sink: random stalls, one long hold on request
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      labeled_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_labels.size() == 0) begin
            note_mismatch("word with no expectation", 32'd0, 32'(rsp_if.byte_out));
         end else begin
            want = expected_labels.pop_front();
            if (rsp_if.byte_out !== want.data)
               note_mismatch("byte_out", 32'(want.data), 32'(rsp_if.byte_out));
            if (rsp_if.byte_kind !== want.kind)
               note_mismatch("byte_kind", 32'(want.kind), 32'(rsp_if.byte_kind));
            if (rsp_if.header_done !== want.done)
               note_mismatch("header_done", 32'(want.done), 32'(rsp_if.header_done));
            if (rsp_if.parse_error !== want.err)
               note_mismatch("parse_error", 32'(want.err), 32'(rsp_if.parse_error));
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid        <= 1'b0;
      req_if.data_byte    <= '0;
      req_if.stream_start <= 1'b0;
      clear_parse();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_header();
      test_wellformed_streams(850);
      test_input_stall();
      test_broken_streams(1300);
      req_if.valid <= 1'b0;
      while (expected_labels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bhsp_pkg.sv
hw/rtl/bhsp_req_if.sv
hw/rtl/bhsp_rsp_if.sv
hw/rtl/bam_header_skip_parser.sv
hw/rtl/bhsp_checker.sv
dv/tb.sv
